FILE: design/gra_pkg.sv
// Types and constants shared by the GB2312 glyph ROM addresser.
`default_nettype none
package gra_pkg;

	// Glyph kinds reported with each request
	typedef enum logic [1:0] {
		KIND_HANZI   = 2'd0,
		KIND_SYMBOL  = 2'd1,
		KIND_ASCII16 = 2'd2,
		KIND_ASCII7  = 2'd3
	} glyph_kind_t;

	// Byte classes
	localparam logic [7:0] BYTE_END       = 8'h00;
	localparam logic [7:0] HANZI_LEAD_LO  = 8'hB0;
	localparam logic [7:0] HANZI_LEAD_HI  = 8'hF7;
	localparam logic [7:0] SYMBOL_LEAD_LO = 8'hA1;
	localparam logic [7:0] SYMBOL_LEAD_HI = 8'hA3;
	localparam logic [7:0] TRAIL_LO       = 8'hA1;
	localparam logic [7:0] PRINT_LO       = 8'h20;
	localparam logic [7:0] PRINT_HI       = 8'h7E;

	// Font ROM layout
	localparam logic [12:0] ROW_GLYPHS    = 13'd94;
	localparam logic [12:0] HANZI_OFFSET  = 13'd846;
	localparam logic [17:0] ASCII16_BASE  = 18'h3CF80;
	localparam logic [17:0] ASCII7_BASE   = 18'h3BFC0;

	// Column steps per glyph kind
	localparam logic [7:0] STEP_WIDE      = 8'd16;
	localparam logic [7:0] STEP_ASCII16   = 8'd8;
	localparam logic [7:0] STEP_ASCII7    = 8'd6;

	// One font ROM request
	typedef struct packed {
		logic [17:0] glyph_address;
		glyph_kind_t glyph_kind;
		logic [7:0]  draw_column;
		logic [7:0]  draw_page;
		logic        draw_inverted;
	} glyph_req_t;

endpackage
`default_nettype wire

FILE: design/gra_text_if.sv
// Text byte channel into the addresser.
`default_nettype none
interface gra_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       first_of_string;
	logic [7:0] start_column;
	logic [7:0] start_page;
	logic       invert;

	modport source (
		output valid, text_byte, first_of_string, start_column, start_page, invert,
		input  ready
	);
	modport sink (
		input  valid, text_byte, first_of_string, start_column, start_page, invert,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/gra_glyph_if.sv
// Glyph request channel out of the addresser.
`default_nettype none
interface gra_glyph_if;
	logic        valid;
	logic        ready;
	logic [17:0] glyph_address;
	logic [1:0]  glyph_kind;
	logic [7:0]  draw_column;
	logic [7:0]  draw_page;
	logic        draw_inverted;

	modport source (
		output valid, glyph_address, glyph_kind, draw_column, draw_page, draw_inverted,
		input  ready
	);
	modport sink (
		input  valid, glyph_address, glyph_kind, draw_column, draw_page, draw_inverted,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/gra_cfg_if.sv
// Configuration write channel carrying the font mode register.
`default_nettype none
interface gra_cfg_if;
	logic valid;
	logic ready;
	logic font_mode;

	modport source (
		output valid, font_mode,
		input  ready
	);
	modport sink (
		input  valid, font_mode,
		output ready
	);
endinterface
`default_nettype wire

FILE: design/gb2312_glyph_rom_addresser_core.sv
// Top level of the GB2312 glyph ROM addresser.
`default_nettype none
// Takes one text byte per cycle and issues one font ROM request for each
// displayable glyph: a 16x16 hanzi or symbol for a GB2312 pair, an 8x16 glyph
// for printable ASCII in mixed mode, or a 5x7 glyph in ASCII-only mode. A byte
// is decoded in the cycle it is accepted and its request is registered in the
// output or skid register. The block takes a byte every cycle; the only limit
// is the two-entry output buffer (output register plus skid register), which
// drops text ready while both entries hold requests not yet taken. Bytes that
// produce no request (lead bytes, skipped bytes, the terminator) never wait on
// the output side except when that buffer is full. The font mode register is
// written through cfg, which is always ready, and should change only while
// the block is idle.
module gb2312_glyph_rom_addresser_core (
	input  wire          clk,
	input  wire          arst_n,
	gra_text_if.sink     text,
	gra_glyph_if.source  glyph,
	gra_cfg_if.sink      cfg
);
	import gra_pkg::*;

	// Stream state
	logic       font_mode_q;
	logic       lead_pending_q;
	logic [7:0] lead_byte_q;
	logic [7:0] cursor_column_q;
	logic [7:0] cursor_page_q;
	logic       string_ended_q;

	// Next state and decoded request
	logic       lead_pending_d;
	logic [7:0] lead_byte_d;
	logic [7:0] cursor_column_d;
	logic [7:0] cursor_page_d;
	logic       string_ended_d;
	logic       emit;
	glyph_req_t req;

	// Output buffer
	glyph_req_t out_q;
	glyph_req_t skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;

	logic accept;
	logic take;
	logic push;
	logic out_load;

	// Decode helpers
	logic [7:0]  col;
	logic [7:0]  page;
	logic        pend;
	logic        ended;
	logic        printable;
	logic        lead_class;
	logic        hanzi_pair;
	logic [6:0]  hanzi_row;
	logic [1:0]  symbol_row;
	logic [6:0]  trail_off;
	logic [6:0]  ascii_off;
	logic [12:0] hanzi_idx;
	logic [12:0] symbol_idx;

	assign accept = text.valid && text.ready;
	assign take   = glyph.valid && glyph.ready;
	assign push   = accept && emit;

	// Word offsets into the font ROM
	always_comb begin
		hanzi_row  = 7'(lead_byte_q - HANZI_LEAD_LO);
		symbol_row = 2'(lead_byte_q - SYMBOL_LEAD_LO);
		trail_off  = 7'(text.text_byte - TRAIL_LO);
		ascii_off  = 7'(text.text_byte - PRINT_LO);
		hanzi_idx  = 13'(hanzi_row) * ROW_GLYPHS + 13'(trail_off) + HANZI_OFFSET;
		symbol_idx = 13'(symbol_row) * ROW_GLYPHS + 13'(trail_off);
		printable  = (text.text_byte >= PRINT_LO) && (text.text_byte <= PRINT_HI);
		lead_class = ((text.text_byte >= HANZI_LEAD_LO) && (text.text_byte <= HANZI_LEAD_HI))
			|| ((text.text_byte >= SYMBOL_LEAD_LO) && (text.text_byte <= SYMBOL_LEAD_HI));
		hanzi_pair = (lead_byte_q >= HANZI_LEAD_LO) && (lead_byte_q <= HANZI_LEAD_HI);
	end

	// Decode one byte against the current stream state
	always_comb begin
		col   = text.first_of_string ? text.start_column : cursor_column_q;
		page  = text.first_of_string ? text.start_page : cursor_page_q;
		pend  = !text.first_of_string && lead_pending_q;
		ended = !text.first_of_string && string_ended_q;

		lead_pending_d  = pend;
		lead_byte_d     = lead_byte_q;
		cursor_column_d = col;
		cursor_page_d   = page;
		string_ended_d  = ended;

		emit              = 1'b0;
		req.glyph_address = '0;
		req.glyph_kind    = KIND_ASCII16;
		req.draw_column   = col;
		req.draw_page     = page;
		req.draw_inverted = text.invert;

		if (!ended) begin
			if (font_mode_q) begin
				// 5x7 mode: ASCII only, drop any pending lead
				lead_pending_d = 1'b0;
				if (text.text_byte == BYTE_END) begin
					string_ended_d = 1'b1;
				end else if (printable) begin
					emit              = 1'b1;
					req.glyph_kind    = KIND_ASCII7;
					req.glyph_address = 18'({ascii_off, 3'b000}) + ASCII7_BASE;
					cursor_column_d   = col + STEP_ASCII7;
				end
			end else if (pend && (text.text_byte >= TRAIL_LO)) begin
				// Complete a 16x16 pair
				lead_pending_d  = 1'b0;
				emit            = 1'b1;
				cursor_column_d = col + STEP_WIDE;
				if (hanzi_pair) begin
					req.glyph_kind    = KIND_HANZI;
					req.glyph_address = {hanzi_idx, 5'b00000};
				end else begin
					req.glyph_kind    = KIND_SYMBOL;
					req.glyph_address = {symbol_idx, 5'b00000};
				end
			end else begin
				// Handle the byte on its own, dropping a lead with a low trail
				lead_pending_d = 1'b0;
				if (text.text_byte == BYTE_END) begin
					string_ended_d = 1'b1;
				end else if (lead_class) begin
					lead_pending_d = 1'b1;
					lead_byte_d    = text.text_byte;
				end else if (printable) begin
					emit              = 1'b1;
					req.glyph_kind    = KIND_ASCII16;
					req.glyph_address = 18'({ascii_off, 4'b0000}) + ASCII16_BASE;
					cursor_column_d   = col + STEP_ASCII16;
				end
			end
		end
	end

	// Advance stream state on each accepted byte; take config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_mode_q     <= 1'b0;
			lead_pending_q  <= 1'b0;
			lead_byte_q     <= '0;
			cursor_column_q <= '0;
			cursor_page_q   <= '0;
			string_ended_q  <= 1'b1;
		end else begin
			if (cfg.valid) begin
				font_mode_q <= cfg.font_mode;
			end
			if (accept) begin
				lead_pending_q  <= lead_pending_d;
				lead_byte_q     <= lead_byte_d;
				cursor_column_q <= cursor_column_d;
				cursor_page_q   <= cursor_page_d;
				string_ended_q  <= string_ended_d;
			end
		end
	end

	// Output buffer occupancy
	assign out_load = (take && skid_valid_q) || (push && (!out_valid_q || take));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (push) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// Hold request payloads
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : req;
		end
		if (push && out_valid_q && !take) begin
			skid_q <= req;
		end
	end

	assign text.ready          = !skid_valid_q;
	assign cfg.ready           = 1'b1;
	assign glyph.valid         = out_valid_q;
	assign glyph.glyph_address = out_q.glyph_address;
	assign glyph.glyph_kind    = out_q.glyph_kind;
	assign glyph.draw_column   = out_q.draw_column;
	assign glyph.draw_page     = out_q.draw_page;
	assign glyph.draw_inverted = out_q.draw_inverted;

endmodule
`default_nettype wire

FILE: tb/gb2312_glyph_rom_addresser_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GB2312 glyph ROM addresser core.
module gb2312_glyph_rom_addresser_core_test;
	import gra_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int STALL_CYCLES   = 300;

	localparam logic FONT_MIXED  = 1'b0;
	localparam logic FONT_ASCII7 = 1'b1;

	logic clk;
	logic arst_n;

	gra_text_if  text_bus ();
	gra_glyph_if glyph_bus ();
	gra_cfg_if   cfg_bus ();

	gb2312_glyph_rom_addresser_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_bus),
		.glyph  (glyph_bus),
		.cfg    (cfg_bus)
	);

	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	int idle_cycles;
	int fail_count;

	// Shadow of the decoder state
	logic       mode_ascii7;
	logic       lead_held;
	logic [7:0] lead_val;
	logic [7:0] cur_col;
	logic [7:0] cur_page;
	logic       text_done;

	glyph_req_t pending_glyphs[$];

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Decode one accepted text byte and queue the request it should produce
	function automatic void predict_glyph(logic [7:0] b, logic first, logic [7:0] col,
			logic [7:0] page, logic inv);
		glyph_req_t  req;
		glyph_kind_t kind;
		int unsigned bv;
		int unsigned lv;
		int unsigned addr;
		logic [7:0]  step;
		bit          hit;
		bit          paired;
		bv = b;
		lv = lead_val;
		addr = 0;
		step = '0;
		kind = KIND_HANZI;
		hit = 1'b0;
		paired = 1'b0;
		if (first) begin
			cur_col = col;
			cur_page = page;
			lead_held = 1'b0;
			text_done = 1'b0;
		end
		if (text_done)
			return;
		if (mode_ascii7) begin
			lead_held = 1'b0;
			if (b == BYTE_END) begin
				text_done = 1'b1;
			end else if (b >= PRINT_LO && b <= PRINT_HI) begin
				addr = (bv - PRINT_LO) * 8 + ASCII7_BASE;
				kind = KIND_ASCII7;
				step = STEP_ASCII7;
				hit = 1'b1;
			end
		end else begin
			// Complete a held lead when the trail is high enough
			if (lead_held) begin
				lead_held = 1'b0;
				if (b >= TRAIL_LO) begin
					if (lead_val >= HANZI_LEAD_LO && lead_val <= HANZI_LEAD_HI) begin
						addr = ((lv - HANZI_LEAD_LO) * ROW_GLYPHS + (bv - TRAIL_LO)
							+ HANZI_OFFSET) * 32;
						kind = KIND_HANZI;
					end else begin
						addr = ((lv - SYMBOL_LEAD_LO) * ROW_GLYPHS + (bv - TRAIL_LO)) * 32;
						kind = KIND_SYMBOL;
					end
					step = STEP_WIDE;
					hit = 1'b1;
					paired = 1'b1;
				end
			end
			// Handle the byte on its own
			if (!paired) begin
				if (b == BYTE_END) begin
					text_done = 1'b1;
				end else if ((b >= HANZI_LEAD_LO && b <= HANZI_LEAD_HI) ||
						(b >= SYMBOL_LEAD_LO && b <= SYMBOL_LEAD_HI)) begin
					lead_held = 1'b1;
					lead_val = b;
				end else if (b >= PRINT_LO && b <= PRINT_HI) begin
					addr = (bv - PRINT_LO) * 16 + ASCII16_BASE;
					kind = KIND_ASCII16;
					step = STEP_ASCII16;
					hit = 1'b1;
				end
			end
		end
		if (hit) begin
			req.glyph_address = addr[17:0];
			req.glyph_kind    = kind;
			req.draw_column   = cur_col;
			req.draw_page     = cur_page;
			req.draw_inverted = inv;
			pending_glyphs.push_back(req);
			cur_col = cur_col + step;
		end
	endfunction

	// Offer one text byte, hold it until taken, then predict
	task automatic send_text(input logic [7:0] b, input logic first, input logic [7:0] col,
			input logic [7:0] page, input logic inv);
		while ($urandom_range(99) < send_idle_pct) begin
			text_bus.valid <= 1'b0;
			@(posedge clk);
		end
		text_bus.valid           <= 1'b1;
		text_bus.text_byte       <= b;
		text_bus.first_of_string <= first;
		text_bus.start_column    <= col;
		text_bus.start_page      <= page;
		text_bus.invert          <= inv;
		@(posedge clk);
		while (!text_bus.ready) @(posedge clk);
		predict_glyph(b, first, col, page, inv);
	endtask

	// Send a byte with random position and invert fields
	task automatic send_byte(input logic [7:0] b, input logic first);
		send_text(b, first, 8'($urandom_range(255)), 8'($urandom_range(255)),
			1'($urandom_range(1)));
	endtask

	// Drop valid, wait for every queued request, then let the pipe settle
	task automatic wait_idle();
		text_bus.valid <= 1'b0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the font mode register while the block is idle
	task automatic set_font_mode(input logic m);
		wait_idle();
		cfg_bus.valid     <= 1'b1;
		cfg_bus.font_mode <= m;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		mode_ascii7 = m;
	endtask

	task automatic test_ignored_after_reset();
		send_text("A", 1'b0, 8'h10, 8'h01, 1'b1);
	endtask

	task automatic test_ascii16_extremes();
		send_text(PRINT_LO, 1'b1, 8'h00, 8'h00, 1'b0);
		send_text(PRINT_HI, 1'b0, 8'hFF, 8'hFF, 1'b1);
	endtask

	// Skipped bytes must not move the column
	task automatic test_skipped_bytes();
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	// Hanzi and symbol pairs at the code range edges; invert comes from the trail
	task automatic test_gb2312_pairs();
		send_text(HANZI_LEAD_LO, 1'b0, 8'h00, 8'h00, 1'b1);
		send_text(TRAIL_LO, 1'b0, 8'h00, 8'h00, 1'b0);
		send_text(HANZI_LEAD_HI, 1'b0, 8'h00, 8'h00, 1'b0);
		send_text(8'hFF, 1'b0, 8'h00, 8'h00, 1'b1);
		send_byte(SYMBOL_LEAD_LO, 1'b0);
		send_byte(TRAIL_LO, 1'b0);
		send_byte(SYMBOL_LEAD_HI, 1'b0);
		send_byte(8'hFE, 1'b0);
	endtask

	// Lead with a low trail, lead then terminator, bytes after the end
	task automatic test_broken_pairs();
		send_byte(8'hB5, 1'b0);
		send_byte("A", 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(BYTE_END, 1'b0);
		send_byte("B", 1'b0);
	endtask

	task automatic test_column_wrap();
		send_text("x", 1'b1, 8'hFA, 8'hFF, 1'b0);
		send_byte("y", 1'b0);
	endtask

	task automatic test_ascii7_mode();
		set_font_mode(FONT_ASCII7);
		send_text(PRINT_LO, 1'b1, 8'hFF, 8'h80, 1'b1);
		send_byte(PRINT_HI, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(BYTE_END, 1'b0);
	endtask

	// A lead held across a switch to 5x7 is dropped
	task automatic test_mode_change_mid_string();
		set_font_mode(FONT_MIXED);
		send_text(HANZI_LEAD_LO, 1'b1, 8'h20, 8'h03, 1'b0);
		set_font_mode(FONT_ASCII7);
		send_byte("C", 1'b0);
		set_font_mode(FONT_MIXED);
		send_byte(SYMBOL_LEAD_LO, 1'b0);
		send_byte("D", 1'b0);
	endtask

	// Hold the output off so the buffer fills and text ready drops
	task automatic test_output_stall();
		int i;
		stall_left = STALL_CYCLES;
		send_byte("S", 1'b1);
		for (i = 0; i < 30; i++)
			send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)), 1'b0);
	endtask

	// Mostly well-formed text with random content, plus noise and broken pairs
	task automatic run_random_text(input int count);
		int   sent;
		int   pick;
		logic first;
		sent = 0;
		while (sent < count) begin
			first = 1'b0;
			if (text_done) begin
				if ($urandom_range(19) == 0) begin
					send_byte(8'($urandom_range(255)), 1'b0);
					continue;
				end
				first = 1'b1;
			end else if ($urandom_range(49) == 0) begin
				first = 1'b1;
			end
			pick = $urandom_range(99);
			if (mode_ascii7) begin
				if (pick < 70)
					send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)), first);
				else if (pick < 80)
					send_byte(8'($urandom_range(8'hFF, 8'h80)), first);
				else if (pick < 88)
					send_byte(8'($urandom_range(8'h1F, 8'h01)), first);
				else if (pick < 94)
					send_byte(BYTE_END, first);
				else
					send_byte(8'($urandom_range(255)), first);
				sent++;
			end else if (pick < 35) begin
				send_byte(8'($urandom_range(PRINT_HI, PRINT_LO)), first);
				sent++;
			end else if (pick < 55) begin
				send_byte(8'($urandom_range(HANZI_LEAD_HI, HANZI_LEAD_LO)), first);
				send_byte(8'($urandom_range(8'hFF, TRAIL_LO)), 1'b0);
				sent += 2;
			end else if (pick < 65) begin
				send_byte(8'($urandom_range(SYMBOL_LEAD_HI, SYMBOL_LEAD_LO)), first);
				send_byte(8'($urandom_range(8'hFF, TRAIL_LO)), 1'b0);
				sent += 2;
			end else if (pick < 72) begin
				send_byte(BYTE_END, first);
				sent++;
			end else if (pick < 80) begin
				if ($urandom_range(1))
					send_byte(8'($urandom_range(HANZI_LEAD_HI, HANZI_LEAD_LO)), first);
				else
					send_byte(8'($urandom_range(SYMBOL_LEAD_HI, SYMBOL_LEAD_LO)), first);
				send_byte(8'($urandom_range(8'hA0, 8'h00)), 1'b0);
				sent += 2;
			end else if (pick < 88) begin
				case ($urandom_range(3))
					0: begin
						send_byte(8'($urandom_range(8'h1F, 8'h01)), first);
					end
					1: begin
						send_byte(8'($urandom_range(8'hA0, 8'h7F)), first);
					end
					2: begin
						send_byte(8'($urandom_range(8'hAF, 8'hA4)), first);
					end
					default: begin
						send_byte(8'($urandom_range(8'hFF, 8'hF8)), first);
					end
				endcase
				sent++;
			end else begin
				send_byte(8'($urandom_range(255)), first);
				sent++;
			end
		end
	endtask

	// One random pass through both font modes under the given idling
	task automatic test_random_phase(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_font_mode(FONT_MIXED);
		run_random_text(200);
		set_font_mode(FONT_ASCII7);
		run_random_text(60);
		set_font_mode(FONT_MIXED);
		run_random_text(40);
	endtask

	// Receiver: random ready, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (stall_left > 0) begin
			glyph_bus.ready <= 1'b0;
			stall_left--;
		end else begin
			glyph_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each taken request with the oldest prediction
	always @(posedge clk) begin
		glyph_req_t want;
		if (arst_n && glyph_bus.valid && glyph_bus.ready) begin
			if (pending_glyphs.size() == 0) begin
				$error("unexpected glyph request: glyph_address %h", glyph_bus.glyph_address);
				fail_count++;
			end else begin
				want = pending_glyphs.pop_front();
				if (glyph_bus.glyph_address !== want.glyph_address) begin
					$error("glyph_address expected %h actual %h", want.glyph_address,
						glyph_bus.glyph_address);
					fail_count++;
				end
				if (glyph_bus.glyph_kind !== want.glyph_kind) begin
					$error("glyph_kind expected %0d actual %0d", want.glyph_kind,
						glyph_bus.glyph_kind);
					fail_count++;
				end
				if (glyph_bus.draw_column !== want.draw_column) begin
					$error("draw_column expected %0d actual %0d", want.draw_column,
						glyph_bus.draw_column);
					fail_count++;
				end
				if (glyph_bus.draw_page !== want.draw_page) begin
					$error("draw_page expected %0d actual %0d", want.draw_page,
						glyph_bus.draw_page);
					fail_count++;
				end
				if (glyph_bus.draw_inverted !== want.draw_inverted) begin
					$error("draw_inverted expected %0d actual %0d", want.draw_inverted,
						glyph_bus.draw_inverted);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run after too long without any request moving
	always @(posedge clk) begin
		if ((text_bus.valid && text_bus.ready) || (glyph_bus.valid && glyph_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Main sequence
	initial begin
		arst_n                   = 1'b0;
		text_bus.valid           = 1'b0;
		text_bus.text_byte       = '0;
		text_bus.first_of_string = 1'b0;
		text_bus.start_column    = '0;
		text_bus.start_page      = '0;
		text_bus.invert          = 1'b0;
		cfg_bus.valid            = 1'b0;
		cfg_bus.font_mode        = FONT_MIXED;
		glyph_bus.ready          = 1'b0;
		send_idle_pct            = 13;
		recv_idle_pct            = 55;
		stall_left               = 0;
		idle_cycles              = 0;
		fail_count               = 0;
		mode_ascii7              = FONT_MIXED;
		lead_held                = 1'b0;
		lead_val                 = '0;
		cur_col                  = '0;
		cur_page                 = '0;
		text_done                = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_after_reset();
		test_ascii16_extremes();
		test_skipped_bytes();
		test_gb2312_pairs();
		test_broken_pairs();
		test_column_wrap();
		test_ascii7_mode();
		test_mode_change_mid_string();
		test_output_stall();
		test_random_phase(13, 55);
		test_random_phase(55, 13);
		test_random_phase(0, 0);

		wait_idle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
design/gra_pkg.sv
design/gra_text_if.sv
design/gra_glyph_if.sv
design/gra_cfg_if.sv
design/gb2312_glyph_rom_addresser_core.sv
tb/gb2312_glyph_rom_addresser_core_test.sv
